@@ rtl/tia_pkg.sv @@
// package for the tagged integer alu
// operation codes and default sizes, no dependencies
package tia_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int MODE_W         = 5;

    localparam logic [MODE_W-1:0] MODE_ADD   = 5'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 5'd1;
    localparam logic [MODE_W-1:0] MODE_LT    = 5'd2;
    localparam logic [MODE_W-1:0] MODE_GT    = 5'd3;
    localparam logic [MODE_W-1:0] MODE_LE    = 5'd4;
    localparam logic [MODE_W-1:0] MODE_GE    = 5'd5;
    localparam logic [MODE_W-1:0] MODE_EQ    = 5'd6;
    localparam logic [MODE_W-1:0] MODE_NE    = 5'd7;
    localparam logic [MODE_W-1:0] MODE_MUL   = 5'd8;
    localparam logic [MODE_W-1:0] MODE_EXACT = 5'd9;
    localparam logic [MODE_W-1:0] MODE_MOD   = 5'd10;
    localparam logic [MODE_W-1:0] MODE_DIV   = 5'd11;
    localparam logic [MODE_W-1:0] MODE_QUO   = 5'd12;
    localparam logic [MODE_W-1:0] MODE_AND   = 5'd13;
    localparam logic [MODE_W-1:0] MODE_OR    = 5'd14;
    localparam logic [MODE_W-1:0] MODE_XOR   = 5'd15;
    localparam logic [MODE_W-1:0] MODE_SHIFT = 5'd16;

endpackage

@@ rtl/tia_in_if.sv @@
// input channel of the tagged integer alu: valid, ready, operation word
// depends on tia_pkg
interface tia_in_if #(
    parameter int VALUE_BITS = tia_pkg::VALUE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [tia_pkg::MODE_W-1:0]    mode;
    logic signed [VALUE_BITS-1:0]  left_operand;
    logic signed [VALUE_BITS-1:0]  right_operand;

    modport source (output valid, output mode, output left_operand,
                    output right_operand, input ready);
    modport sink   (input valid, input mode, input left_operand,
                    input right_operand, output ready);
endinterface

@@ rtl/tia_out_if.sv @@
// result channel of the tagged integer alu: valid, ready, result word
// depends on tia_pkg
interface tia_out_if #(
    parameter int VALUE_BITS = tia_pkg::VALUE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          truth;
    logic                          fail;

    modport source (output valid, output value, output truth, output fail,
                    input ready);
    modport sink   (input valid, input value, input truth, input fail,
                    output ready);
endinterface

@@ rtl/tagged_integer_alu.sv @@
// tagged integer alu, top level: decode stage, bit-per-stage divide and
// multiply array, result stage; depends on tia_pkg, tia_in_if, tia_out_if

// The block takes one word per cycle unless the result side stalls, and returns
// one result word per input, in order, after the stage 0 register, the divide
// and multiply array and the result register. The array resolves one quotient
// bit and adds one partial product in each of its VALUE_BITS stages. A stall
// on the result side holds the whole pipeline; input ready is low only while
// the last stage holds a word that has not been taken.
module tagged_integer_alu #(
    parameter int VALUE_BITS = tia_pkg::VALUE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tia_in_if.sink    i_in,
    tia_out_if.source o_out
);

    localparam int W   = VALUE_BITS;
    localparam int SHW = $clog2(W);
    localparam int MW  = tia_pkg::MODE_W;

    // pipeline advance
    logic adv;
    logic r_out_vld;
    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = adv;

    // stage registers, index s holds the word after s array steps
    logic          r_vld  [0:W];
    logic [MW-1:0] r_mode [0:W];
    logic          r_sa   [0:W];
    logic          r_sb   [0:W];
    logic [W-1:0]  r_b    [0:W];
    logic [W-1:0]  r_ma   [0:W];
    logic [W-1:0]  r_mb   [0:W];
    logic [W-1:0]  r_dvd  [0:W];
    logic [W-1:0]  r_rem  [0:W];
    logic [W-1:0]  r_q    [0:W];
    logic [2*W-1:0] r_acc [0:W];
    logic [W-1:0]  r_sv   [0:W];
    logic          r_st   [0:W];
    logic          r_sf   [0:W];

    // decode and the operations that need no array steps
    logic signed [W-1:0] a, b;
    logic signed [W:0]   sum, dif;
    logic [W-1:0]        n_ma, n_mb;
    logic [SHW-1:0]      rcnt;
    logic signed [W-1:0] rsh, lsh, lback;
    logic                lfail;
    logic [W-1:0]        n_sv;
    logic                n_st, n_sf;

    assign a   = i_in.left_operand;
    assign b   = i_in.right_operand;
    assign sum = {a[W-1], a} + {b[W-1], b};
    assign dif = {a[W-1], a} - {b[W-1], b};
    assign n_ma = a[W-1] ? W'(-a) : W'(a);
    assign n_mb = b[W-1] ? W'(-b) : W'(b);
    assign rcnt = (n_mb >= W'(W)) ? SHW'(W - 1) : n_mb[SHW-1:0];
    assign rsh   = a >>> rcnt;
    assign lsh   = a <<< b[SHW-1:0];
    assign lback = lsh >>> b[SHW-1:0];
    assign lfail = (a != '0) && ((b >= W'(W)) || (lback != a));

    always_comb begin
        n_sv = '0;
        n_st = 1'b0;
        n_sf = 1'b0;
        case (i_in.mode)
            tia_pkg::MODE_ADD: begin
                n_sf = sum[W] ^ sum[W-1];
                n_sv = n_sf ? '0 : sum[W-1:0];
            end
            tia_pkg::MODE_SUB: begin
                n_sf = dif[W] ^ dif[W-1];
                n_sv = n_sf ? '0 : dif[W-1:0];
            end
            tia_pkg::MODE_LT: n_st = a < b;
            tia_pkg::MODE_GT: n_st = a > b;
            tia_pkg::MODE_LE: n_st = a <= b;
            tia_pkg::MODE_GE: n_st = a >= b;
            tia_pkg::MODE_EQ: n_st = a == b;
            tia_pkg::MODE_NE: n_st = a != b;
            tia_pkg::MODE_MUL, tia_pkg::MODE_EXACT, tia_pkg::MODE_MOD,
            tia_pkg::MODE_DIV, tia_pkg::MODE_QUO: n_sf = 1'b0;
            tia_pkg::MODE_AND: n_sv = a & b;
            tia_pkg::MODE_OR:  n_sv = a | b;
            tia_pkg::MODE_XOR: n_sv = a ^ b;
            tia_pkg::MODE_SHIFT: begin
                if (b[W-1]) begin
                    n_sv = rsh;
                end else begin
                    n_sf = lfail;
                    n_sv = (lfail || a == '0) ? '0 : lsh;
                end
            end
            default: n_sf = 1'b1;
        endcase
    end

    // stage 0 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in.valid;
        end
        if (adv) begin
            r_mode[0] <= i_in.mode;
            r_sa[0]   <= a[W-1];
            r_sb[0]   <= b[W-1];
            r_b[0]    <= b;
            r_ma[0]   <= n_ma;
            r_mb[0]   <= n_mb;
            r_dvd[0]  <= n_ma;
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
            r_acc[0]  <= '0;
            r_sv[0]   <= n_sv;
            r_st[0]   <= n_st;
            r_sf[0]   <= n_sf;
        end
    end

    // divide and multiply array: one quotient bit and one partial product
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]     t;
        logic           take;
        logic [W-1:0]   n_rem;
        logic [2*W-1:0] pp;

        assign t     = {r_rem[k], r_dvd[k][W-1]};
        assign take  = t >= {1'b0, r_mb[k]};
        assign n_rem = take ? W'(t - {1'b0, r_mb[k]}) : t[W-1:0];
        assign pp    = r_mb[k][k] ? ({{W{1'b0}}, r_ma[k]} << k) : '0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (adv) begin
                r_mode[k+1] <= r_mode[k];
                r_sa[k+1]   <= r_sa[k];
                r_sb[k+1]   <= r_sb[k];
                r_b[k+1]    <= r_b[k];
                r_ma[k+1]   <= r_ma[k];
                r_mb[k+1]   <= r_mb[k];
                r_dvd[k+1]  <= {r_dvd[k][W-2:0], 1'b0};
                r_rem[k+1]  <= n_rem;
                r_q[k+1]    <= {r_q[k][W-2:0], take};
                r_acc[k+1]  <= r_acc[k] + pp;
                r_sv[k+1]   <= r_sv[k];
                r_st[k+1]   <= r_st[k];
                r_sf[k+1]   <= r_sf[k];
            end
        end
    end

    // sign fix-up, floor adjust and range checks
    logic [W-1:0]        q, rem, fb;
    logic [2*W-1:0]      prod, plim, pneg;
    logic                qneg, adj, dz, qok, fok, mfail;
    logic signed [W+1:0] tq, fq;
    logic signed [W:0]   fm;
    logic [W-1:0]        n_val;
    logic                n_tru, n_fail;

    assign q    = r_q[W];
    assign rem  = r_rem[W];
    assign fb   = r_b[W];
    assign prod = r_acc[W];
    assign qneg = r_sa[W] ^ r_sb[W];
    assign dz   = r_mb[W] == '0;
    assign adj  = (rem != '0) && qneg;
    assign tq   = qneg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    assign fq   = adj ? $signed(~{2'b00, q}) : tq;
    assign qok  = (tq[W+1:W-1] == 3'b000) || (tq[W+1:W-1] == 3'b111);
    assign fok  = (fq[W+1:W-1] == 3'b000) || (fq[W+1:W-1] == 3'b111);

    always_comb begin
        if (adj) begin
            fm = r_sa[W] ? ($signed({fb[W-1], fb}) - $signed({1'b0, rem}))
                         : ($signed({fb[W-1], fb}) + $signed({1'b0, rem}));
        end else begin
            fm = r_sa[W] ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
        end
    end

    assign plim  = qneg ? ((2*W)'(1) << (W - 1))
                        : (((2*W)'(1) << (W - 1)) - (2*W)'(1));
    assign pneg  = -prod;
    assign mfail = prod > plim;

    always_comb begin
        n_val  = r_sv[W];
        n_tru  = r_st[W];
        n_fail = r_sf[W];
        case (r_mode[W])
            tia_pkg::MODE_MUL: begin
                n_fail = mfail;
                n_val  = mfail ? '0 : (qneg ? pneg[W-1:0] : prod[W-1:0]);
            end
            tia_pkg::MODE_EXACT: begin
                n_fail = dz || (rem != '0) || !qok;
                n_val  = n_fail ? '0 : tq[W-1:0];
            end
            tia_pkg::MODE_MOD: begin
                n_fail = dz;
                n_val  = dz ? '0 : fm[W-1:0];
            end
            tia_pkg::MODE_DIV: begin
                n_fail = dz || !fok;
                n_val  = n_fail ? '0 : fq[W-1:0];
            end
            tia_pkg::MODE_QUO: begin
                n_fail = dz || !qok;
                n_val  = n_fail ? '0 : tq[W-1:0];
            end
            default: n_fail = r_sf[W];
        endcase
    end

    // result register
    logic [W-1:0] r_val;
    logic         r_tru, r_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vld[W];
        end
        if (adv) begin
            r_val  <= n_val;
            r_tru  <= n_tru;
            r_fail <= n_fail;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.value = r_val;
    assign o_out.truth = r_tru;
    assign o_out.fail  = r_fail;

endmodule

@@ tb/tia_checker.sv @@
// result checker for the tagged integer alu: predicts each result word from
// the accepted operation words and compares in order; depends on tia_pkg
module tia_checker #(
    parameter int VALUE_BITS = tia_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [tia_pkg::MODE_W-1:0]   i_mode,
    input  logic signed [VALUE_BITS-1:0] i_left,
    input  logic signed [VALUE_BITS-1:0] i_right,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_truth,
    input  logic                         i_fail,
    output int                           o_errors,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         truth;
        logic                         fail;
    } t_alu_result;

    localparam longint VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    t_alu_result expected_results[$];

    // compute the result word of one operation
    function automatic t_alu_result compute_alu(logic [tia_pkg::MODE_W-1:0] m,
                                                longint a, longint b);
        t_alu_result r;
        longint v, q, rm, n;
        logic t, f;
        v = 0; t = 0; f = 0;
        case (m)
            tia_pkg::MODE_ADD: v = a + b;
            tia_pkg::MODE_SUB: v = a - b;
            tia_pkg::MODE_LT:  t = a < b;
            tia_pkg::MODE_GT:  t = a > b;
            tia_pkg::MODE_LE:  t = a <= b;
            tia_pkg::MODE_GE:  t = a >= b;
            tia_pkg::MODE_EQ:  t = a == b;
            tia_pkg::MODE_NE:  t = a != b;
            tia_pkg::MODE_MUL: v = a * b;
            tia_pkg::MODE_EXACT, tia_pkg::MODE_MOD, tia_pkg::MODE_DIV,
            tia_pkg::MODE_QUO: begin
                if (b == 0) begin
                    f = 1;
                end else begin
                    q = a / b;
                    rm = a % b;
                    if (m == tia_pkg::MODE_EXACT) begin
                        if (rm != 0) f = 1; else v = q;
                    end else if (m == tia_pkg::MODE_MOD) begin
                        v = (rm != 0 && ((rm < 0) != (b < 0))) ? rm + b : rm;
                    end else if (m == tia_pkg::MODE_DIV) begin
                        v = (rm != 0 && ((rm < 0) != (b < 0))) ? q - 1 : q;
                    end else begin
                        v = q;
                    end
                end
            end
            tia_pkg::MODE_AND: v = a & b;
            tia_pkg::MODE_OR:  v = a | b;
            tia_pkg::MODE_XOR: v = a ^ b;
            tia_pkg::MODE_SHIFT: begin
                if (b < 0) begin
                    n = (-b > 62) ? 62 : -b;
                    v = a >>> n;
                end else if (a != 0) begin
                    // operands fit in VALUE_BITS, so a count past it overflows
                    if (b >= VALUE_BITS) f = 1;
                    else v = a <<< b;
                end
            end
            default: f = 1;
        endcase
        if (v > VMAX || v < VMIN) f = 1;
        if (f) v = 0;
        r.value = v[VALUE_BITS-1:0];
        r.truth = t;
        r.fail  = f;
        return r;
    endfunction

    // predict on accepted input words, compare on accepted result words
    always @(posedge i_clk) begin
        t_alu_result got, want;
        if (i_rst_n && i_in_valid && i_in_ready)
            expected_results.push_back(compute_alu(i_mode, longint'(i_left),
                                                   longint'(i_right)));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got = '{i_value, i_truth, i_fail};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word v=%0d t=%0b f=%0b",
                         $time, i_value, i_truth, i_fail);
                o_errors <= o_errors + 1;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    $display({"%0t: mismatch expected v=%0d t=%0b f=%0b",
                              " actual v=%0d t=%0b f=%0b"},
                             $time, want.value, want.truth, want.fail,
                             got.value, got.truth, got.fail);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

@@ tb/tb_tagged_integer_alu.sv @@
// testbench top for the tagged integer alu: clock, reset, stimulus, verdict
// depends on tia_pkg, tia_in_if, tia_out_if, tia_checker and the rtl
module tb_tagged_integer_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = tia_pkg::VALUE_BITS_DEF;
    localparam int WATCHDOG = 2000;
    localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    // highest code, outside the defined operations
    localparam logic [tia_pkg::MODE_W-1:0] MODE_BAD = 5'd31;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending;
    int   send_idle_pct, recv_idle_pct;
    int   idle_cycles;
    bit   stim_done;

    tia_in_if  #(.VALUE_BITS(VB)) in_ch ();
    tia_out_if #(.VALUE_BITS(VB)) out_ch ();

    tagged_integer_alu #(.VALUE_BITS(VB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    tia_checker #(.VALUE_BITS(VB)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_mode(in_ch.mode),
        .i_left(in_ch.left_operand), .i_right(in_ch.right_operand),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_value(out_ch.value), .i_truth(out_ch.truth), .i_fail(out_ch.fail),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls at random
    always @(posedge i_clk)
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // random operand biased toward edges and small values
    function automatic longint pick_operand();
        case ($urandom_range(7))
            0: return VMAX - $urandom_range(2);
            1: return VMIN + $urandom_range(2);
            2, 3: return longint'($urandom_range(40)) - 20;
            default: return longint'($signed(VB'($urandom())));
        endcase
    endfunction

    // present one word and hold it until accepted
    task automatic send_word(logic [tia_pkg::MODE_W-1:0] m, longint a, longint b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= m;
        in_ch.left_operand <= a[VB-1:0];
        in_ch.right_operand <= b[VB-1:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        logic [tia_pkg::MODE_W-1:0] m;
        longint a, b;
        m = ($urandom_range(19) == 0) ? tia_pkg::MODE_W'($urandom_range(31, 17))
                                      : tia_pkg::MODE_W'($urandom_range(16));
        a = pick_operand();
        b = pick_operand();
        if (m == tia_pkg::MODE_SHIFT && $urandom_range(1))
            b = longint'($urandom_range(80)) - 40;
        // exact divides half the time with a divisor that fits
        if (m == tia_pkg::MODE_EXACT && $urandom_range(1) && b != 0) a = (a / b) * b;
        send_word(m, a, b);
    endtask

    initial begin
        int phase;
        in_ch.valid = 0;
        in_ch.mode = '0;
        in_ch.left_operand = '0;
        in_ch.right_operand = '0;
        send_idle_pct = 17;
        recv_idle_pct = 77;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // extremes and special cases
        send_word(tia_pkg::MODE_ADD, VMAX, 1);
        send_word(tia_pkg::MODE_SUB, VMIN, 1);
        send_word(tia_pkg::MODE_LT, VMIN, VMAX);
        send_word(tia_pkg::MODE_GT, VMAX, VMIN);
        send_word(tia_pkg::MODE_LE, 5, 5);
        send_word(tia_pkg::MODE_GE, -1, 0);
        send_word(tia_pkg::MODE_EQ, VMIN, VMIN);
        send_word(tia_pkg::MODE_NE, 3, 3);
        send_word(tia_pkg::MODE_MUL, VMIN, -1);
        send_word(tia_pkg::MODE_MUL, 32768, -32768);
        send_word(tia_pkg::MODE_EXACT, 7, 2);
        send_word(tia_pkg::MODE_EXACT, VMIN, -1);
        send_word(tia_pkg::MODE_EXACT, 12, 0);
        send_word(tia_pkg::MODE_MOD, -7, 2);
        send_word(tia_pkg::MODE_MOD, 7, -2);
        send_word(tia_pkg::MODE_DIV, -7, 2);
        send_word(tia_pkg::MODE_QUO, -7, 2);
        send_word(tia_pkg::MODE_DIV, VMIN, -1);
        send_word(tia_pkg::MODE_AND, -1, VMAX);
        send_word(tia_pkg::MODE_OR, VMIN, 1);
        send_word(tia_pkg::MODE_XOR, -1, VMAX);
        send_word(tia_pkg::MODE_SHIFT, 9, 0);
        send_word(tia_pkg::MODE_SHIFT, VMIN, VMIN);
        send_word(tia_pkg::MODE_SHIFT, 1, VB - 2);
        send_word(tia_pkg::MODE_SHIFT, 0, VMAX);
        send_word(tia_pkg::MODE_SHIFT, 1, VB - 1);
        send_word(MODE_BAD, 1, 1);

        // random part over three idling patterns
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 77 : 0;
            recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 17 : 0;
            repeat (600) send_random_word();
        end
        in_ch.valid <= 0;
        stim_done = 1;
    end

    // drain and give the verdict
    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (VB + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tia_pkg.sv
rtl/tia_in_if.sv
rtl/tia_out_if.sv
rtl/tagged_integer_alu.sv
tb/tia_checker.sv
tb/tb_tagged_integer_alu.sv
